// ----- src/assert_macros.svh -----
// Assertion helpers for the RTL, included by beep_pattern_sequencer.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- src/bps_pkg.sv -----
`default_nettype none

package bps_pkg;

    // Field widths
    localparam int CMD_W      = 2;
    localparam int PAT_W      = 3;
    localparam int TIME_W     = 32;
    localparam int SPAN_W     = 16;
    localparam int BEEPS_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Stream widths: tdata padded to whole bytes
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 8;

    // Register reset values
    localparam logic [SPAN_W-1:0] SHORT_BEEP_RST = 16'd80;
    localparam logic [SPAN_W-1:0] LONG_BEEP_RST  = 16'd600;
    localparam logic [SPAN_W-1:0] GAP_RST        = 16'd80;
    localparam logic [SPAN_W-1:0] ALARM_HALF_RST = 16'd300;
    localparam logic              ACTIVE_HI_RST  = 1'b1;

    // Beep counts per pattern
    localparam logic [BEEPS_W-1:0] ONE_BEEP   = 2'd1;
    localparam logic [BEEPS_W-1:0] EXIT_BEEPS = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK = 2'd0,
        CMD_PLAY = 2'd1,
        CMD_STOP = 2'd2,
        CMD_NOP  = 2'd3
    } cmd_t;

    typedef enum logic [PAT_W-1:0] {
        PAT_NONE  = 3'd0,
        PAT_ENTER = 3'd1,
        PAT_EXIT  = 3'd2,
        PAT_FULL  = 3'd3,
        PAT_ALARM = 3'd4
    } pattern_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHORT_BEEP = 3'd0,
        REG_LONG_BEEP  = 3'd1,
        REG_GAP        = 3'd2,
        REG_ALARM_HALF = 3'd3,
        REG_ACTIVE_HI  = 3'd4
    } cfg_idx_t;

    // Configuration register set
    typedef struct packed {
        logic [SPAN_W-1:0] short_beep_ms;
        logic [SPAN_W-1:0] long_beep_ms;
        logic [SPAN_W-1:0] gap_ms;
        logic [SPAN_W-1:0] alarm_half_period_ms;
        logic              active_high;
    } cfg_t;

    // Status after one item
    typedef struct packed {
        logic running;
        logic tone_on;
    } status_t;

endpackage

`default_nettype wire

// ----- src/bps_cfg_regs.sv -----
`default_nettype none

module bps_cfg_regs
    import bps_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Always take a write
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode the register index; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_SHORT_BEEP: cfg_next.short_beep_ms        = cfg_data;
                REG_LONG_BEEP:  cfg_next.long_beep_ms         = cfg_data;
                REG_GAP:        cfg_next.gap_ms               = cfg_data;
                REG_ALARM_HALF: cfg_next.alarm_half_period_ms = cfg_data;
                REG_ACTIVE_HI:  cfg_next.active_high          = cfg_data[0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_beep_ms        <= SHORT_BEEP_RST;
            cfg_reg.long_beep_ms         <= LONG_BEEP_RST;
            cfg_reg.gap_ms               <= GAP_RST;
            cfg_reg.alarm_half_period_ms <= ALARM_HALF_RST;
            cfg_reg.active_high          <= ACTIVE_HI_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/bps_core.sv -----
`default_nettype none

module bps_core
    import bps_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfg_t              cfg,
    input  wire logic              step,
    input  wire logic [CMD_W-1:0]  cmd,
    input  wire logic [PAT_W-1:0]  pattern,
    input  wire logic [TIME_W-1:0] now,
    output status_t                status_next
);

    logic                running_reg, running_next;
    logic                tone_on_reg, tone_on_next;
    logic                looping_reg, looping_next;
    logic [BEEPS_W-1:0]  beeps_reg, beeps_next;
    logic [SPAN_W-1:0]   on_span_reg, on_span_next;
    logic [SPAN_W-1:0]   off_span_reg, off_span_next;
    logic [TIME_W-1:0]   deadline_reg, deadline_next;

    logic [TIME_W-1:0]   elapsed;
    logic                expired;
    logic [BEEPS_W-1:0]  beeps_dec;
    logic [SPAN_W-1:0]   play_on_span;

    // Wrap-safe deadline check: reached when now - deadline is not negative
    assign elapsed   = now - deadline_reg;
    assign expired   = running_reg && !elapsed[TIME_W-1];
    assign beeps_dec = looping_reg ? beeps_reg : beeps_reg - ONE_BEEP;

    // On span picked by the pattern being started
    always_comb
    begin
        unique case (pattern_t'(pattern))
            PAT_FULL:  play_on_span = cfg.long_beep_ms;
            PAT_ALARM: play_on_span = cfg.alarm_half_period_ms;
            default:   play_on_span = cfg.short_beep_ms;
        endcase
    end

    // Next state for one item
    always_comb
    begin
        running_next  = running_reg;
        tone_on_next  = tone_on_reg;
        looping_next  = looping_reg;
        beeps_next    = beeps_reg;
        on_span_next  = on_span_reg;
        off_span_next = off_span_reg;
        deadline_next = deadline_reg;

        unique case (cmd_t'(cmd))
            CMD_TICK:
            begin
                if (expired)
                begin
                    if (tone_on_reg)
                    begin
                        // end of tone: count down and go idle or start the gap
                        tone_on_next = 1'b0;
                        beeps_next   = beeps_dec;
                        if (!looping_reg && beeps_dec == '0)
                            running_next = 1'b0;
                        else
                            deadline_next = now + TIME_W'(off_span_reg);
                    end
                    else
                    begin
                        // end of gap: sound again
                        tone_on_next  = 1'b1;
                        deadline_next = now + TIME_W'(on_span_reg);
                    end
                end
            end
            CMD_PLAY:
            begin
                looping_next = 1'b0;
                case (pattern_t'(pattern)) inside
                    PAT_ENTER, PAT_EXIT, PAT_FULL, PAT_ALARM:
                    begin
                        running_next  = 1'b1;
                        tone_on_next  = 1'b1;
                        on_span_next  = play_on_span;
                        deadline_next = now + TIME_W'(play_on_span);
                        if (pattern_t'(pattern) == PAT_ALARM)
                        begin
                            looping_next  = 1'b1;
                            beeps_next    = ONE_BEEP;
                            off_span_next = cfg.alarm_half_period_ms;
                        end
                        else
                        begin
                            beeps_next    = (pattern_t'(pattern) == PAT_EXIT) ? EXIT_BEEPS
                                                                              : ONE_BEEP;
                            off_span_next = cfg.gap_ms;
                        end
                    end
                    default:
                    begin
                        // none or unknown pattern silences the buzzer
                        running_next = 1'b0;
                        tone_on_next = 1'b0;
                        beeps_next   = '0;
                    end
                endcase
            end
            CMD_STOP:
            begin
                running_next = 1'b0;
                tone_on_next = 1'b0;
                looping_next = 1'b0;
                beeps_next   = '0;
            end
            default:
            begin
                // no operation
                running_next = running_reg;
            end
        endcase
    end

    assign status_next.running = running_next;
    assign status_next.tone_on = tone_on_next;

    // Commit the state when the item moves on to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg  <= 1'b0;
            tone_on_reg  <= 1'b0;
            looping_reg  <= 1'b0;
            beeps_reg    <= '0;
            on_span_reg  <= '0;
            off_span_reg <= '0;
            deadline_reg <= '0;
        end
        else if (step)
        begin
            running_reg  <= running_next;
            tone_on_reg  <= tone_on_next;
            looping_reg  <= looping_next;
            beeps_reg    <= beeps_next;
            on_span_reg  <= on_span_next;
            off_span_reg <= off_span_next;
            deadline_reg <= deadline_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/beep_pattern_sequencer.sv -----
// Buzzer pattern sequencer.
// Input stream (s_axis): one item per transfer; tuser carries the command
// (tick, play, stop, no-op), tdata the pattern and the millisecond timestamp.
// Output stream (m_axis): exactly one result per input item, in order:
// the buzzer pin level with polarity applied, the tone state and busy.
// Configuration channel (cfg_*): register index and data; writes are always
// taken and must only be issued while no item is in flight.
// Path: an item accepted into the input register is decided and moved into the
// result register once that register frees up; its result is offered from then on.
// Throughput: one item per cycle while m_axis_tready stays high; the input register,
// the decision logic (one 32-bit subtract for the deadline check and adds for the next
// deadline) and the result register work as a registered pipeline.
// Stall: while the receiver holds m_axis_tready low the result stays put and
// one more item waits in the input register; then s_axis_tready drops.
// Reset: the buzzer is idle and silent, durations take their default values
// (80, 600, 80, 300 ms, active high), both stream registers are empty.
`default_nettype none

`include "assert_macros.svh"

module beep_pattern_sequencer
    import bps_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // [2:0] pattern, [34:3] now, [39:35] zero
    input  wire logic [CMD_W-1:0]      s_axis_tuser,  // [1:0] cmd
    // result stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // [0] pin_level, [1] sounding,
                                                      // [2] busy_res, [7:3] zero
    // configuration writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t               cfg;
    status_t            status_next;

    logic               in_valid_reg;
    logic [CMD_W-1:0]   in_cmd_reg;
    logic [PAT_W-1:0]   in_pattern_reg;
    logic [TIME_W-1:0]  in_now_reg;

    logic               out_valid_reg;
    logic               out_pin_reg;
    logic               out_sounding_reg;
    logic               out_busy_reg;

    logic               advance;
    logic               in_take;

    // Move the held item into the result register when that register frees up
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    bps_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bps_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .step        (advance),
        .cmd         (in_cmd_reg),
        .pattern     (in_pattern_reg),
        .now         (in_now_reg),
        .status_next (status_next)
    );

    // Input register: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    // Input register: payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_cmd_reg     <= s_axis_tuser;
            in_pattern_reg <= s_axis_tdata[PAT_W-1:0];
            in_now_reg     <= s_axis_tdata[PAT_W +: TIME_W];
        end
    end

    // Result register: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    // Result register: payload, polarity applied to the pin
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_pin_reg      <= status_next.tone_on ? cfg.active_high : !cfg.active_high;
            out_sounding_reg <= status_next.tone_on;
            out_busy_reg     <= status_next.running;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-3){1'b0}}, out_busy_reg, out_sounding_reg, out_pin_reg};

    // Pin level follows the tone state through the configured polarity
    `ASSERT_CLK(a_pin_polarity, m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[1] ? cfg.active_high : !cfg.active_high)), "pin level does not match tone and polarity")
    // A sounding buzzer always belongs to a running pattern
    `ASSERT_CLK(a_sound_implies_busy, m_axis_tvalid |-> (!m_axis_tdata[1] || m_axis_tdata[2]), "tone on while idle")
    // An item that advances shows up as a result on the next cycle
    `ASSERT_CLK(a_advance_result, advance |=> m_axis_tvalid, "decided item did not reach the result register")
    // Nothing is decided while the input register is empty
    `ASSERT_ALWAYS(a_no_phantom, advance |-> in_valid_reg, "advance without a held item")

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import bps_pkg::*;

    // Pattern codes beyond the defined set; play treats them as stop
    localparam logic [PAT_W-1:0] PAT_SPARE_LO = 3'd5;
    localparam logic [PAT_W-1:0] PAT_SPARE_HI = 3'd7;
    localparam int REPORT_LIMIT = 10;
    localparam int HOLD_OFF_CYCLES = 300;

    typedef struct {
        cmd_t              cmd;
        logic [PAT_W-1:0]  pat;
        logic [TIME_W-1:0] now;
    } buzz_cmd_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    wire                   s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [CMD_W-1:0]      s_axis_tuser = '0;
    wire                   m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    wire [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                  cfg_valid = 1'b0;
    wire                   cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    beep_pattern_sequencer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Commands waiting to be sent, and pin states predicted per transfer
    buzz_cmd_t        cmd_queue[$];
    logic [2:0]       expected_pin_state[$];   // {busy, sounding, pin}

    // Local copy of the buzzer timing registers and sequencer state
    cfg_t              timing;
    logic              bz_running;
    logic              bz_tone;
    logic              bz_looping;
    logic [BEEPS_W-1:0] bz_beeps;
    logic [SPAN_W-1:0] bz_on_span;
    logic [SPAN_W-1:0] bz_off_span;
    logic [TIME_W-1:0] bz_deadline;

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    logic hold_start = 1'b0;
    int  hold_left = 0;
    logic item_taken = 1'b0;

    int  fail_count = 0;
    int  results_checked = 0;
    int  items_sent = 0;
    int  plays_sent = 0;
    int  ticks_sent = 0;
    int  settings_used = 1;
    logic [TIME_W-1:0] clock_ms = '0;

    // Clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #1_000_000;
        $display("beep_pattern_sequencer test failed");
        $finish;
    end

    // Advance the sequencer state by one command and return the pin state
    function automatic logic [2:0] buzzer_step(cmd_t cmd, logic [PAT_W-1:0] pat,
                                               logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] lag;
        logic known;
        lag = now - bz_deadline;
        known = 1'b1;
        case (cmd)
            CMD_TICK:
            begin
                if (bz_running && !lag[TIME_W-1])
                begin
                    if (bz_tone)
                    begin
                        bz_tone = 1'b0;
                        if (!bz_looping)
                            bz_beeps = bz_beeps - ONE_BEEP;
                        if (bz_beeps == '0 && !bz_looping)
                            bz_running = 1'b0;
                        else
                            bz_deadline = now + TIME_W'(bz_off_span);
                    end
                    else
                    begin
                        bz_tone = 1'b1;
                        bz_deadline = now + TIME_W'(bz_on_span);
                    end
                end
            end
            CMD_PLAY:
            begin
                bz_looping = 1'b0;
                case (pat)
                    PAT_ENTER:
                    begin
                        bz_beeps = ONE_BEEP;
                        bz_on_span = timing.short_beep_ms;
                        bz_off_span = timing.gap_ms;
                    end
                    PAT_EXIT:
                    begin
                        bz_beeps = EXIT_BEEPS;
                        bz_on_span = timing.short_beep_ms;
                        bz_off_span = timing.gap_ms;
                    end
                    PAT_FULL:
                    begin
                        bz_beeps = ONE_BEEP;
                        bz_on_span = timing.long_beep_ms;
                        bz_off_span = timing.gap_ms;
                    end
                    PAT_ALARM:
                    begin
                        bz_beeps = ONE_BEEP;
                        bz_looping = 1'b1;
                        bz_on_span = timing.alarm_half_period_ms;
                        bz_off_span = timing.alarm_half_period_ms;
                    end
                    default: known = 1'b0;
                endcase
                if (known)
                begin
                    bz_running = 1'b1;
                    bz_deadline = now + TIME_W'(bz_on_span);
                    bz_tone = 1'b1;
                end
                else
                begin
                    bz_running = 1'b0;
                    bz_beeps = '0;
                    bz_tone = 1'b0;
                end
            end
            CMD_STOP:
            begin
                bz_running = 1'b0;
                bz_looping = 1'b0;
                bz_beeps = '0;
                bz_tone = 1'b0;
            end
            default: ;
        endcase
        return {bz_running, bz_tone, bz_tone ? timing.active_high : ~timing.active_high};
    endfunction

    task automatic note_failure(string what, logic [2:0] want, logic [2:0] got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%0t: %s: expected %b actual %b", $realtime, what, want, got);
    endtask

    // Monitor: predict on input transfers, check output transfers, track writes
    always @(posedge clk)
    begin : watch_ports
        logic [2:0] want;
        item_taken = rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n)
        begin
            if (item_taken)
                expected_pin_state.push_back(buzzer_step(cmd_t'(s_axis_tuser),
                                                         s_axis_tdata[PAT_W-1:0],
                                                         s_axis_tdata[PAT_W +: TIME_W]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_pin_state.size() == 0)
                    note_failure("unexpected result", 3'b000, m_axis_tdata[2:0]);
                else
                begin
                    want = expected_pin_state.pop_front();
                    results_checked++;
                    if (m_axis_tdata[0] !== want[0])
                        note_failure("pin_level", want, m_axis_tdata[2:0]);
                    if (m_axis_tdata[1] !== want[1])
                        note_failure("sounding", want, m_axis_tdata[2:0]);
                    if (m_axis_tdata[2] !== want[2])
                        note_failure("busy_res", want, m_axis_tdata[2:0]);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    REG_SHORT_BEEP: timing.short_beep_ms = cfg_data;
                    REG_LONG_BEEP:  timing.long_beep_ms = cfg_data;
                    REG_GAP:        timing.gap_ms = cfg_data;
                    REG_ALARM_HALF: timing.alarm_half_period_ms = cfg_data;
                    REG_ACTIVE_HI:  timing.active_high = cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // Driver: offer queued commands, idle at random between transfers
    always @(negedge clk)
    begin : drive_input
        buzz_cmd_t next;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || item_taken)
        begin
            if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next = cmd_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= next.cmd;
                s_axis_tdata <= {{(IN_DATA_W - PAT_W - TIME_W){1'b0}}, next.now, next.pat};
                items_sent++;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_start)
        begin
            hold_left = HOLD_OFF_CYCLES;
            hold_start = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic push_cmd(cmd_t cmd, logic [PAT_W-1:0] pat, logic [TIME_W-1:0] now);
        buzz_cmd_t c;
        c.cmd = cmd;
        c.pat = pat;
        c.now = now;
        cmd_queue.push_back(c);
        if (cmd == CMD_PLAY)
            plays_sent++;
        if (cmd == CMD_TICK)
            ticks_sent++;
    endtask

    // Queue a run of mostly ticks with plays mixed in; time moves forward
    // by steps on the scale of the spans, with rare jumps and steps back
    task automatic queue_random_run(int count);
        int r;
        int scale;
        logic [PAT_W-1:0] pat;
        logic [SPAN_W-1:0] widest;
        widest = timing.short_beep_ms;
        if (timing.long_beep_ms > widest)
            widest = timing.long_beep_ms;
        if (timing.gap_ms > widest)
            widest = timing.gap_ms;
        if (timing.alarm_half_period_ms > widest)
            widest = timing.alarm_half_period_ms;
        scale = widest / 2 + 2;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 3)
                clock_ms = $urandom;
            else if (r < 6)
                clock_ms = clock_ms - $urandom_range(0, scale);
            else
                clock_ms = clock_ms + $urandom_range(0, scale);
            pat = PAT_W'($urandom_range(PAT_SPARE_HI));
            r = $urandom_range(99);
            if (r < 9)
            begin
                if ($urandom_range(99) < 85)
                    pat = PAT_W'($urandom_range(PAT_ENTER, PAT_ALARM));
                push_cmd(CMD_PLAY, pat, clock_ms);
            end
            else if (r < 13)
                push_cmd(CMD_STOP, pat, clock_ms);
            else if (r < 16)
                push_cmd(CMD_NOP, pat, clock_ms);
            else
                push_cmd(CMD_TICK, pat, clock_ms);
        end
    endtask

    // Wait until every command is sent and every result is back
    task automatic drain();
        while (cmd_queue.size() > 0 || s_axis_tvalid || expected_pin_state.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all five timing registers back to back
    task automatic write_timing(logic [SPAN_W-1:0] short_ms, logic [SPAN_W-1:0] long_ms,
                                logic [SPAN_W-1:0] gap_ms, logic [SPAN_W-1:0] alarm_ms,
                                logic act_high);
        cfg_idx_t regs[5];
        logic [CFG_DATA_W-1:0] vals[5];
        regs = '{REG_SHORT_BEEP, REG_LONG_BEEP, REG_GAP, REG_ALARM_HALF, REG_ACTIVE_HI};
        vals = '{short_ms, long_ms, gap_ms, alarm_ms, {15'd0, act_high}};
        for (int k = 0; k < 5; k++)
        begin
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= regs[k];
            cfg_data <= vals[k];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        timing.short_beep_ms = SHORT_BEEP_RST;
        timing.long_beep_ms = LONG_BEEP_RST;
        timing.gap_ms = GAP_RST;
        timing.alarm_half_period_ms = ALARM_HALF_RST;
        timing.active_high = ACTIVE_HI_RST;
        bz_running = 1'b0;
        bz_tone = 1'b0;
        bz_looping = 1'b0;
        bz_beeps = '0;
        bz_on_span = '0;
        bz_off_span = '0;
        bz_deadline = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Default timing: light sender gaps, heavy receiver stalls
        send_idle_pct = 7;
        recv_idle_pct = 54;
        push_cmd(CMD_TICK, PAT_SPARE_HI, 32'h0000_0000);          // tick while idle
        push_cmd(CMD_PLAY, PAT_ENTER, 32'hFFFF_FFF0);             // deadline wraps past zero
        push_cmd(CMD_TICK, PAT_NONE, 32'h0000_003F);              // one short of deadline
        push_cmd(CMD_TICK, PAT_NONE, 32'h0000_0040);              // tone ends, go idle
        push_cmd(CMD_PLAY, PAT_EXIT, 32'd100);
        push_cmd(CMD_TICK, PAT_NONE, 32'd180);                    // first beep ends
        push_cmd(CMD_TICK, PAT_NONE, 32'd259);                    // gap not over yet
        push_cmd(CMD_TICK, PAT_NONE, 32'd260);                    // second beep starts
        push_cmd(CMD_TICK, PAT_NONE, 32'd340);                    // second beep ends
        push_cmd(CMD_PLAY, PAT_FULL, 32'd1000);
        push_cmd(CMD_NOP, PAT_ALARM, 32'd2000);                   // no-op keeps state
        push_cmd(CMD_TICK, PAT_NONE, 32'd1600);
        push_cmd(CMD_PLAY, PAT_ALARM, 32'd5000);
        push_cmd(CMD_TICK, PAT_NONE, 32'd5300);                   // alarm goes quiet
        push_cmd(CMD_TICK, PAT_NONE, 32'd5600);                   // alarm sounds again
        push_cmd(CMD_PLAY, PAT_NONE, 32'd6000);                   // pattern none stops
        push_cmd(CMD_PLAY, PAT_ALARM, 32'd7000);
        push_cmd(CMD_PLAY, PAT_SPARE_LO, 32'd7001);               // unknown pattern stops
        push_cmd(CMD_PLAY, PAT_ALARM, 32'd7002);
        push_cmd(CMD_PLAY, PAT_SPARE_HI, 32'd7003);
        push_cmd(CMD_PLAY, PAT_ALARM, 32'd8000);
        push_cmd(CMD_STOP, PAT_ALARM, 32'd8001);
        push_cmd(CMD_PLAY, PAT_ENTER, 32'h0000_0000);
        push_cmd(CMD_TICK, PAT_NONE, 32'h8000_0050);              // half a wrap away: early
        push_cmd(CMD_TICK, PAT_NONE, 32'h8000_004F);              // just inside: late
        push_cmd(CMD_TICK, PAT_NONE, 32'hFFFF_FFFF);
        clock_ms = 32'd9000;
        queue_random_run(125);
        drain();

        // Zero spans, active-low pin
        write_timing(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        queue_random_run(150);
        drain();

        // Longest spans, time near the wrap point; heavy sender gaps
        send_idle_pct = 54;
        recv_idle_pct = 7;
        write_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        clock_ms = 32'hFFFE_0000;
        queue_random_run(150);
        drain();

        write_timing(SPAN_W'($urandom_range(1, 200)), SPAN_W'($urandom_range(1, 200)),
                     SPAN_W'($urandom_range(1, 200)), SPAN_W'($urandom_range(1, 200)),
                     1'($urandom_range(1)));
        queue_random_run(150);
        drain();

        // No idling; the receiver holds off long enough to back up the input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_timing(SPAN_W'($urandom), SPAN_W'($urandom), SPAN_W'($urandom),
                     SPAN_W'($urandom), 1'($urandom_range(1)));
        queue_random_run(150);
        @(posedge clk);
        hold_start = 1'b1;
        drain();

        write_timing(SPAN_W'($urandom_range(0, 20)), SPAN_W'($urandom_range(0, 20)),
                     SPAN_W'($urandom_range(0, 20)), SPAN_W'($urandom_range(0, 20)),
                     1'($urandom_range(1)));
        queue_random_run(200);
        drain();

        repeat (10) @(posedge clk);
        if (expected_pin_state.size() > 0)
            note_failure("result missing", expected_pin_state[0], 3'b000);

        $display("Sent %0d commands (%0d plays, %0d ticks) under %0d timing settings,",
                 items_sent, plays_sent, ticks_sent, settings_used);
        $display("checked %0d results, %0d failures", results_checked, fail_count);
        if (fail_count == 0)
            $display("beep_pattern_sequencer test passed");
        else
            $display("beep_pattern_sequencer test failed");
        $finish;
    end

endmodule

// ----- beep_pattern_sequencer.f -----
+incdir+src
src/bps_pkg.sv
src/bps_cfg_regs.sv
src/bps_core.sv
src/beep_pattern_sequencer.sv
bench/tb.sv
